@@ rtl/ufks_pkg.sv @@
// Shared constants, types and codes for the keyed union-find unit.
package ufks_pkg;

    localparam int MAX_ELEMENTS = 128;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 8;
    localparam int LOAD_IDX_W   = 7;
    localparam int WIDE_W       = (CNT_W > COUNT_W) ? CNT_W + 1 : COUNT_W + 1;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [WIDE_W-1:0]     t_wide;
    typedef logic [LOAD_IDX_W-1:0] t_ridx;
    typedef logic [1:0]            t_code;

    localparam t_code MODE_LOAD  = 2'd0;
    localparam t_code MODE_UNION = 2'd1;
    localparam t_code MODE_FIND  = 2'd2;

    localparam t_code STAT_DONE    = 2'd0;
    localparam t_code STAT_SAME    = 2'd1;
    localparam t_code STAT_MISSING = 2'd2;

endpackage

@@ rtl/ufks_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module ufks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

@@ rtl/union_find_keyed_sets_unit.sv @@
// Keyed union-find unit: one item at a time; a load writes the key and a self parent of one entry,
// a find scans the first element_count keys (saturated at the store depth), then follows
// parent links from the match with one parent read more than the links followed, and reads
// the root key to present the result; a union scans once for both keys and then chases two
// roots. The scan is set by the single read port of the key memory (one entry per cycle) and
// each chase step by the registered read port of the parent memory. The key and parent
// memories are not cleared at reset; entries are defined only once loaded.
module union_find_keyed_sets_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_mode,
    input  logic [ufks_pkg::LOAD_IDX_W-1:0]    i_load_index,
    input  logic signed [ufks_pkg::KEY_W-1:0]  i_key_a,
    input  logic signed [ufks_pkg::KEY_W-1:0]  i_key_b,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic signed [ufks_pkg::KEY_W-1:0]  o_root_key,
    output logic [ufks_pkg::LOAD_IDX_W-1:0]    o_root_index,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ufks_pkg::COUNT_W-1:0]       i_cfg_data
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_CH_RD    = 3'd2;
    localparam logic [2:0] ST_CH_CMP   = 3'd3;
    localparam logic [2:0] ST_KEY_RD   = 3'd4;
    localparam logic [2:0] ST_KEY_WAIT = 3'd5;
    localparam logic [2:0] ST_FINISH   = 3'd6;

    logic [2:0]                   r_state, n_state;
    logic [ufks_pkg::COUNT_W-1:0] r_element_count, n_element_count;
    ufks_pkg::t_code              r_mode, n_mode;
    ufks_pkg::t_key               r_key_a, n_key_a;
    ufks_pkg::t_key               r_key_b, n_key_b;
    ufks_pkg::t_cnt               r_scan_cnt, n_scan_cnt;
    logic                         r_rd_vld, n_rd_vld;
    ufks_pkg::t_idx               r_rd_idx, n_rd_idx;
    logic                         r_found_a, n_found_a;
    logic                         r_found_b, n_found_b;
    ufks_pkg::t_idx               r_idx_a, n_idx_a;
    ufks_pkg::t_idx               r_idx_b, n_idx_b;
    ufks_pkg::t_idx               r_node, n_node;
    ufks_pkg::t_cnt               r_steps, n_steps;
    logic                         r_phase_b, n_phase_b;
    ufks_pkg::t_idx               r_ra, n_ra;
    ufks_pkg::t_code              r_res_status, n_res_status;
    ufks_pkg::t_key               r_res_key, n_res_key;
    ufks_pkg::t_idx               r_res_idx, n_res_idx;
    logic                         r_out_valid, n_out_valid;
    ufks_pkg::t_code              r_out_status, n_out_status;
    ufks_pkg::t_key               r_out_key, n_out_key;
    ufks_pkg::t_ridx              r_out_idx, n_out_idx;

    logic            in_accept;
    logic            out_accept;
    logic            slot_free;
    logic            load_ok;
    logic            root_hit;
    ufks_pkg::t_wide count_wide;
    ufks_pkg::t_cnt  live;

    logic            key_we;
    ufks_pkg::t_idx  key_waddr;
    ufks_pkg::t_key  key_wdata;
    logic            key_re;
    ufks_pkg::t_idx  key_raddr;
    ufks_pkg::t_key  key_rdata;
    logic            par_we;
    ufks_pkg::t_idx  par_waddr;
    ufks_pkg::t_idx  par_wdata;
    logic            par_re;
    ufks_pkg::t_idx  par_rdata;

    ufks_ram #(
        .WIDTH(ufks_pkg::KEY_W),
        .DEPTH(ufks_pkg::MAX_ELEMENTS)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(key_waddr),
        .i_wdata(key_wdata),
        .i_re   (key_re),
        .i_raddr(key_raddr),
        .o_rdata(key_rdata)
    );

    ufks_ram #(
        .WIDTH(ufks_pkg::IDX_W),
        .DEPTH(ufks_pkg::MAX_ELEMENTS)
    ) u_par_ram (
        .i_clk  (i_clk),
        .i_we   (par_we),
        .i_waddr(par_waddr),
        .i_wdata(par_wdata),
        .i_re   (par_re),
        .i_raddr(r_node),
        .o_rdata(par_rdata)
    );

    assign o_in_stall   = (r_state != ST_IDLE);
    assign in_accept    = i_in_valid && !o_in_stall;
    assign out_accept   = r_out_valid && !i_out_stall;
    assign slot_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_root_key   = r_out_key;
    assign o_root_index = r_out_idx;

    // Saturate the searched count at the store depth.
    assign count_wide = ufks_pkg::t_wide'(r_element_count);
    assign live = (count_wide > ufks_pkg::t_wide'(ufks_pkg::MAX_ELEMENTS))
                  ? ufks_pkg::t_cnt'(ufks_pkg::MAX_ELEMENTS)
                  : ufks_pkg::t_cnt'(count_wide);
    assign load_ok = ufks_pkg::t_wide'(i_load_index)
                     < ufks_pkg::t_wide'(ufks_pkg::MAX_ELEMENTS);

    always_comb begin
        n_state         = r_state;
        n_element_count = r_element_count;
        n_mode          = r_mode;
        n_key_a         = r_key_a;
        n_key_b         = r_key_b;
        n_scan_cnt      = r_scan_cnt;
        n_rd_vld        = 1'b0;
        n_rd_idx        = r_rd_idx;
        n_found_a       = r_found_a;
        n_found_b       = r_found_b;
        n_idx_a         = r_idx_a;
        n_idx_b         = r_idx_b;
        n_node          = r_node;
        n_steps         = r_steps;
        n_phase_b       = r_phase_b;
        n_ra            = r_ra;
        n_res_status    = r_res_status;
        n_res_key       = r_res_key;
        n_res_idx       = r_res_idx;
        n_out_valid     = r_out_valid;
        n_out_status    = r_out_status;
        n_out_key       = r_out_key;
        n_out_idx       = r_out_idx;

        key_we    = 1'b0;
        key_waddr = ufks_pkg::t_idx'(i_load_index);
        key_wdata = i_key_a;
        key_re    = 1'b0;
        key_raddr = ufks_pkg::t_idx'(r_scan_cnt);
        par_we    = 1'b0;
        par_waddr = ufks_pkg::t_idx'(i_load_index);
        par_wdata = ufks_pkg::t_idx'(i_load_index);
        par_re    = 1'b0;
        root_hit  = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_element_count = i_cfg_data;
        end
        if (out_accept) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_mode     = i_mode;
                    n_key_a    = i_key_a;
                    n_key_b    = i_key_b;
                    n_scan_cnt = '0;
                    n_found_a  = 1'b0;
                    n_found_b  = 1'b0;
                    n_steps    = '0;
                    n_phase_b  = 1'b0;
                    n_res_status = ufks_pkg::STAT_MISSING;
                    n_res_key    = '0;
                    n_res_idx    = '0;
                    case (i_mode)
                        ufks_pkg::MODE_LOAD: begin
                            n_state = ST_FINISH;
                            if (load_ok) begin
                                key_we       = 1'b1;
                                par_we       = 1'b1;
                                n_res_status = ufks_pkg::STAT_DONE;
                                n_res_key    = i_key_a;
                                n_res_idx    = ufks_pkg::t_idx'(i_load_index);
                            end
                        end
                        ufks_pkg::MODE_UNION, ufks_pkg::MODE_FIND: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // One key read issued per cycle, compared in the cycle after its read.
                if (r_scan_cnt < live) begin
                    key_re     = 1'b1;
                    n_scan_cnt = r_scan_cnt + ufks_pkg::t_cnt'(1);
                end
                n_rd_vld = key_re;
                n_rd_idx = ufks_pkg::t_idx'(r_scan_cnt);
                if (r_rd_vld) begin
                    if (key_rdata == r_key_a && !r_found_a) begin
                        n_found_a = 1'b1;
                        n_idx_a   = r_rd_idx;
                    end
                    if (key_rdata == r_key_b && !r_found_b) begin
                        n_found_b = 1'b1;
                        n_idx_b   = r_rd_idx;
                    end
                end
                if (!key_re && !r_rd_vld) begin
                    if (!r_found_a || (r_mode == ufks_pkg::MODE_UNION && !r_found_b)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_node  = r_idx_a;
                        n_steps = '0;
                        n_state = ST_CH_RD;
                    end
                end
            end
            ST_CH_RD: begin
                if (r_steps == ufks_pkg::t_cnt'(ufks_pkg::MAX_ELEMENTS)) begin
                    root_hit = 1'b1;
                end else begin
                    par_re  = 1'b1;
                    n_state = ST_CH_CMP;
                end
            end
            ST_CH_CMP: begin
                if (par_rdata == r_node
                    || ufks_pkg::t_wide'(par_rdata)
                       >= ufks_pkg::t_wide'(ufks_pkg::MAX_ELEMENTS)) begin
                    root_hit = 1'b1;
                end else begin
                    n_node  = par_rdata;
                    n_steps = r_steps + ufks_pkg::t_cnt'(1);
                    n_state = ST_CH_RD;
                end
            end
            ST_KEY_RD: begin
                key_re    = 1'b1;
                key_raddr = r_ra;
                n_state   = ST_KEY_WAIT;
            end
            ST_KEY_WAIT: begin
                n_res_key = key_rdata;
                n_res_idx = r_ra;
                n_state   = ST_FINISH;
            end
            ST_FINISH: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_key    = r_res_key;
                    n_out_idx    = ufks_pkg::t_ridx'(r_res_idx);
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Root reached: a union chases b next, then links b's root to a's unless equal; then fetch the root key.
        if (root_hit) begin
            if (!r_phase_b) begin
                n_ra = r_node;
                if (r_mode == ufks_pkg::MODE_UNION) begin
                    n_node    = r_idx_b;
                    n_steps   = '0;
                    n_phase_b = 1'b1;
                    n_state   = ST_CH_RD;
                end else begin
                    n_res_status = ufks_pkg::STAT_DONE;
                    n_state      = ST_KEY_RD;
                end
            end else begin
                if (r_node == r_ra) begin
                    n_res_status = ufks_pkg::STAT_SAME;
                end else begin
                    par_we       = 1'b1;
                    par_waddr    = r_node;
                    par_wdata    = r_ra;
                    n_res_status = ufks_pkg::STAT_DONE;
                end
                n_state = ST_KEY_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_element_count <= ufks_pkg::COUNT_W'(1);
            r_out_valid     <= 1'b0;
            r_steps         <= '0;
        end else begin
            r_state         <= n_state;
            r_element_count <= n_element_count;
            r_out_valid     <= n_out_valid;
            r_steps         <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key_a      <= n_key_a;
        r_key_b      <= n_key_b;
        r_scan_cnt   <= n_scan_cnt;
        r_rd_vld     <= n_rd_vld;
        r_rd_idx     <= n_rd_idx;
        r_found_a    <= n_found_a;
        r_found_b    <= n_found_b;
        r_idx_a      <= n_idx_a;
        r_idx_b      <= n_idx_b;
        r_node       <= n_node;
        r_phase_b    <= n_phase_b;
        r_ra         <= n_ra;
        r_res_status <= n_res_status;
        r_res_key    <= n_res_key;
        r_res_idx    <= n_res_idx;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_idx    <= n_out_idx;
    end

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_FINISH)
        else $error("result raised outside finish state");

    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= ufks_pkg::t_cnt'(ufks_pkg::MAX_ELEMENTS))
        else $error("parent chase ran past store depth");

    a_link_not_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (par_we && r_state != ST_IDLE) |-> par_wdata != par_waddr)
        else $error("union linked a root to itself");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input taken again before item finished");

endmodule
